@@ src/generational_handle_table_unit_defines.svh @@
// assertion macros shared by the handle table checker
`ifndef GENERATIONAL_HANDLE_TABLE_UNIT_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define GHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define GHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ght_pkg.sv @@
// shared types and constants of the generational handle table
package ght_pkg;

  // default table depth and location limits
  localparam int unsigned ENTRY_COUNT_DEF = 1024;
  localparam int unsigned CHUNK_COUNT     = 256;
  localparam int unsigned SLOTS_PER_CHUNK = 1024;

  // generation at which an index is retired
  localparam logic [31:0] GEN_MAX = 32'hFFFF_FFFF;

  // request codes
  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RESOLVE = 2'd1,
    REQ_REMOVE  = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_STALE     = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP_GEN,
    S_CLEAR
  } state_t;

endpackage

@@ src/generational_handle_table_unit.sv @@
// generational handle table: allocate, resolve, remove and clear of handles
//
// Command channel: a request transfers at a rising edge with start high and
// busy low; req_type selects allocate, resolve, remove or clear all, the other
// fields are sampled with it. busy stays high until the request is finished.
// Result channel: done is high for exactly one cycle with status, out_index,
// out_generation, out_chunk, out_slot and out_batch_last; the receiver cannot
// stall, so it must take the result in that cycle.
// Resolve, remove and an allocate that issues a fresh index finish in the
// execute state; an allocate that pops a freed index goes on to a second
// read of the entry table for its generation, and clear all walks the
// issued entries one a cycle through the single entry table read port.
// A new request may transfer in the cycle that done is high, but none is
// taken before the last one is finished.
// Reset (rst, synchronous) empties the free stack and the issued count; no
// clearing pass is needed, since entries at or above the issued count are
// never read and a freshly issued entry is written in full.
module generational_handle_table_unit #(
  parameter int unsigned ENTRY_COUNT = ght_pkg::ENTRY_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [31:0] handle_index,
  input  logic [31:0] handle_generation,
  input  logic [7:0]  new_chunk,
  input  logic [9:0]  new_slot,
  input  logic [9:0]  moved_index,
  input  logic        batch_last,
  output logic        done,
  output logic [1:0]  status,
  output logic [9:0]  out_index,
  output logic [31:0] out_generation,
  output logic [7:0]  out_chunk,
  output logic [9:0]  out_slot,
  output logic        out_batch_last
);

  localparam int unsigned IDX_W = $clog2(ENTRY_COUNT);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] ENTRY_CNT = CNT_W'(ENTRY_COUNT);

  // entry tables and free stack
  logic [32:0]      meta_mem  [ENTRY_COUNT];  // {live, generation}
  logic [18:0]      loc_mem   [ENTRY_COUNT];  // {valid, chunk, slot}
  logic [IDX_W-1:0] stack_mem [ENTRY_COUNT];

  logic [IDX_W-1:0] ent_raddr, stack_raddr;
  logic [32:0]      meta_q;
  logic [18:0]      loc_q;
  logic [IDX_W-1:0] stack_q;
  logic             meta_we, loc_we, stack_we;
  logic [IDX_W-1:0] meta_waddr, loc_waddr, stack_waddr;
  logic [32:0]      meta_wdata;
  logic [18:0]      loc_wdata;
  logic [IDX_W-1:0] stack_wdata_w;

  // control and request registers
  ght_pkg::state_t  state, state_next;
  ght_pkg::req_t    req_q, req_q_next;
  logic [31:0]      hidx_q, hidx_q_next;
  logic [31:0]      hgen_q, hgen_q_next;
  logic [7:0]       chunk_q, chunk_q_next;
  logic [9:0]       slot_q, slot_q_next;
  logic [9:0]       midx_q, midx_q_next;
  logic             blast_q, blast_q_next;
  logic [IDX_W-1:0] idx_q, idx_q_next;
  logic [CNT_W-1:0] free_count, free_count_next;
  logic [CNT_W-1:0] issued_count, issued_count_next;
  logic [CNT_W-1:0] scan_ptr, scan_ptr_next;
  logic             scan_pend, scan_pend_next;
  logic [IDX_W-1:0] scan_idx, scan_idx_next;

  // result registers
  logic             done_next;
  logic [1:0]       status_next;
  logic [9:0]       out_index_next, out_slot_next;
  logic [31:0]      out_generation_next;
  logic [7:0]       out_chunk_next;
  logic             out_batch_last_next;

  // result of the current step
  logic             fin;
  ght_pkg::status_t res_status;
  logic [31:0]      res_index, res_gen;
  logic [7:0]       res_chunk;
  logic [9:0]       res_slot;

  // helper values
  logic [CNT_W-1:0] fc_m1;
  logic [31:0]      issued32, midx32, idx32;
  logic             handle_ok, move_ok;

  assign busy = (state != ght_pkg::S_IDLE);

  // table memories: registered reads, one write port each
  always_ff @(posedge clk) begin
    meta_q  <= meta_mem[ent_raddr];
    loc_q   <= loc_mem[ent_raddr];
    stack_q <= stack_mem[stack_raddr];
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (loc_we) begin
      loc_mem[loc_waddr] <= loc_wdata;
    end
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata_w;
    end
  end

  // handle checks on the entry read back
  assign fc_m1    = free_count - CNT_W'(1);
  assign issued32 = 32'(issued_count);
  assign midx32   = 32'(midx_q);
  assign idx32    = 32'(idx_q);
  assign handle_ok = (hidx_q != ght_pkg::GEN_MAX) && (hidx_q < issued32) &&
                     meta_q[32] && (meta_q[31:0] == hgen_q) && loc_q[18] &&
                     (32'(loc_q[17:10]) < ght_pkg::CHUNK_COUNT) &&
                     (32'(loc_q[9:0]) < ght_pkg::SLOTS_PER_CHUNK);
  assign move_ok = (midx32 != hidx_q) && (midx32 < issued32) &&
                   (midx32 < ENTRY_COUNT);

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ght_pkg::S_IDLE;
      done         <= 1'b0;
      free_count   <= '0;
      issued_count <= '0;
      scan_pend    <= 1'b0;
    end else begin
      state        <= state_next;
      done         <= done_next;
      free_count   <= free_count_next;
      issued_count <= issued_count_next;
      scan_pend    <= scan_pend_next;
    end
    req_q          <= req_q_next;
    hidx_q         <= hidx_q_next;
    hgen_q         <= hgen_q_next;
    chunk_q        <= chunk_q_next;
    slot_q         <= slot_q_next;
    midx_q         <= midx_q_next;
    blast_q        <= blast_q_next;
    idx_q          <= idx_q_next;
    scan_ptr       <= scan_ptr_next;
    scan_idx       <= scan_idx_next;
    status         <= status_next;
    out_index      <= out_index_next;
    out_generation <= out_generation_next;
    out_chunk      <= out_chunk_next;
    out_slot       <= out_slot_next;
    out_batch_last <= out_batch_last_next;
  end

  // sequencer: next state, memory controls and results
  always_comb begin
    state_next        = state;
    req_q_next        = req_q;
    hidx_q_next       = hidx_q;
    hgen_q_next       = hgen_q;
    chunk_q_next      = chunk_q;
    slot_q_next       = slot_q;
    midx_q_next       = midx_q;
    blast_q_next      = blast_q;
    idx_q_next        = idx_q;
    free_count_next   = free_count;
    issued_count_next = issued_count;
    scan_ptr_next     = scan_ptr;
    scan_pend_next    = scan_pend;
    scan_idx_next     = scan_idx;

    ent_raddr     = hidx_q[IDX_W-1:0];
    stack_raddr   = fc_m1[IDX_W-1:0];
    meta_we       = 1'b0;
    meta_waddr    = hidx_q[IDX_W-1:0];
    meta_wdata    = meta_q;
    loc_we        = 1'b0;
    loc_waddr     = midx32[IDX_W-1:0];
    loc_wdata     = {1'b1, chunk_q, slot_q};
    stack_we      = 1'b0;
    stack_waddr   = free_count[IDX_W-1:0];
    stack_wdata_w = hidx_q[IDX_W-1:0];

    fin        = 1'b0;
    res_status = ght_pkg::ST_OK;
    res_index  = '0;
    res_gen    = '0;
    res_chunk  = '0;
    res_slot   = '0;

    case (state)
      ght_pkg::S_IDLE: begin
        // take a request and start the table reads at once
        ent_raddr = handle_index[IDX_W-1:0];
        if (start) begin
          req_q_next   = ght_pkg::req_t'(req_type);
          hidx_q_next  = handle_index;
          hgen_q_next  = handle_generation;
          chunk_q_next = new_chunk;
          slot_q_next  = new_slot;
          midx_q_next  = moved_index;
          blast_q_next = batch_last;
          if (ght_pkg::req_t'(req_type) == ght_pkg::REQ_CLEAR) begin
            scan_ptr_next  = '0;
            scan_pend_next = 1'b0;
            state_next     = ght_pkg::S_CLEAR;
          end else begin
            state_next = ght_pkg::S_EXEC;
          end
        end
      end

      ght_pkg::S_EXEC: begin
        case (req_q)
          ght_pkg::REQ_ALLOC: begin
            if (free_count != '0) begin
              // pop a freed index, its generation is read next
              free_count_next = fc_m1;
              idx_q_next      = stack_q;
              ent_raddr       = stack_q;
              state_next      = ght_pkg::S_POP_GEN;
            end else if (issued_count < ENTRY_CNT) begin
              // fresh index starts at generation zero
              meta_we           = 1'b1;
              meta_waddr        = issued_count[IDX_W-1:0];
              meta_wdata        = {1'b1, 32'd0};
              loc_we            = 1'b1;
              loc_waddr         = issued_count[IDX_W-1:0];
              issued_count_next = issued_count + CNT_W'(1);
              res_index         = issued32;
              fin               = 1'b1;
            end else begin
              res_status = ght_pkg::ST_EXHAUSTED;
              fin        = 1'b1;
            end
          end
          ght_pkg::REQ_RESOLVE, ght_pkg::REQ_REMOVE: begin
            fin = 1'b1;
            if (!handle_ok) begin
              res_status = ght_pkg::ST_STALE;
            end else begin
              res_index = hidx_q;
              res_gen   = meta_q[31:0];
              res_chunk = loc_q[17:10];
              res_slot  = loc_q[9:0];
              if (req_q == ght_pkg::REQ_REMOVE) begin
                // release the entry; a retired generation is not recycled
                meta_we = 1'b1;
                if (meta_q[31:0] == ght_pkg::GEN_MAX) begin
                  meta_wdata = {1'b0, meta_q[31:0]};
                end else begin
                  meta_wdata = {1'b0, meta_q[31:0] + 32'd1};
                  if (free_count < ENTRY_CNT) begin
                    stack_we        = 1'b1;
                    free_count_next = free_count + CNT_W'(1);
                  end
                end
                // the swapped-in neighbour takes over the freed location
                if (move_ok) begin
                  loc_we    = 1'b1;
                  loc_wdata = {1'b1, loc_q[17:0]};
                end
              end
            end
          end
          default: begin
            state_next = ght_pkg::S_IDLE;
          end
        endcase
      end

      ght_pkg::S_POP_GEN: begin
        // recycled index keeps its bumped generation
        meta_we    = 1'b1;
        meta_waddr = idx_q;
        meta_wdata = {1'b1, meta_q[31:0]};
        loc_we     = 1'b1;
        loc_waddr  = idx_q;
        res_index  = idx32;
        res_gen    = meta_q[31:0];
        fin        = 1'b1;
      end

      ght_pkg::S_CLEAR: begin
        // release the entry read last cycle while reading the next one;
        // a released entry is not live, so its location valid bit is moot
        ent_raddr     = scan_ptr[IDX_W-1:0];
        meta_waddr    = scan_idx;
        stack_wdata_w = scan_idx;
        if (scan_pend && meta_q[32]) begin
          meta_we = 1'b1;
          if (meta_q[31:0] == ght_pkg::GEN_MAX) begin
            meta_wdata = {1'b0, meta_q[31:0]};
          end else begin
            meta_wdata = {1'b0, meta_q[31:0] + 32'd1};
            if (free_count < ENTRY_CNT) begin
              stack_we        = 1'b1;
              free_count_next = free_count + CNT_W'(1);
            end
          end
        end
        if (scan_ptr < issued_count) begin
          scan_pend_next = 1'b1;
          scan_idx_next  = scan_ptr[IDX_W-1:0];
          scan_ptr_next  = scan_ptr + CNT_W'(1);
        end else begin
          scan_pend_next = 1'b0;
          if (!scan_pend) begin
            fin = 1'b1;
          end
        end
      end

      default: begin
        state_next = ght_pkg::S_IDLE;
      end
    endcase

    // result transfer goes out with the return to idle
    done_next           = fin;
    status_next         = status;
    out_index_next      = out_index;
    out_generation_next = out_generation;
    out_chunk_next      = out_chunk;
    out_slot_next       = out_slot;
    out_batch_last_next = out_batch_last;
    if (fin) begin
      state_next          = ght_pkg::S_IDLE;
      status_next         = res_status;
      out_index_next      = res_index[9:0];
      out_generation_next = res_gen;
      out_chunk_next      = res_chunk;
      out_slot_next       = res_slot;
      out_batch_last_next = blast_q;
    end
  end

endmodule

@@ src/ght_checker.sv @@
// port-level checker for the handle table, bound to the top level
`include "generational_handle_table_unit_defines.svh"

module ght_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [9:0]  out_index,
  input logic [31:0] out_generation,
  input logic [7:0]  out_chunk,
  input logic [9:0]  out_slot
);

  // a result shows only once the request has finished
  `GHT_ASSERT_NOW(a_done_idle, done, !busy, "result transfer while still busy")

  // an accepted request holds the block busy
  `GHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request left block idle")

  // every finished request gives its result
  `GHT_ASSERT_NOW(a_finish_done, !$past(rst) && $fell(busy), done, "request ended without result")

  // a failed request carries no handle or location
  `GHT_ASSERT_NOW(a_fail_zero, done && (status != ght_pkg::ST_OK), (out_index == 10'd0) && (out_generation == 32'd0) && (out_chunk == 8'd0) && (out_slot == 10'd0), "failed result carries data")

endmodule

bind generational_handle_table_unit ght_checker u_ght_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .status(status),
  .out_index(out_index),
  .out_generation(out_generation),
  .out_chunk(out_chunk),
  .out_slot(out_slot)
);
